// ----- hdl/lpm_pkg.sv -----
// types and codes for the ipv4 longest prefix match route table
// used by the channel interfaces and the top level; depends on nothing
package lpm_pkg;

  localparam int SLOT_W = 4;
  localparam int PORT_W = 2;
  localparam int ADDR_W = 32;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } lpm_op_t;

  typedef struct packed {
    lpm_op_t             op;
    logic [SLOT_W-1:0]   slot;
    logic                entry_enable;
    logic [ADDR_W-1:0]   entry_prefix;
    logic [ADDR_W-1:0]   entry_mask;
    logic [ADDR_W-1:0]   entry_gateway;
    logic [PORT_W-1:0]   entry_port;
    logic [ADDR_W-1:0]   lookup_address;
  } lpm_req_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   matched_slot;
    logic [ADDR_W-1:0]   next_hop;
    logic [PORT_W-1:0]   out_port;
    logic [ADDR_W-1:0]   match_mask;
  } lpm_rsp_t;

  // one stored route, valid mark kept apart in flops
  typedef struct packed {
    logic [ADDR_W-1:0]   prefix;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   gateway;
    logic [PORT_W-1:0]   port;
  } route_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } lpm_state_t;

endpackage

// ----- hdl/lpm_if.sv -----
// valid/ready channels for requests and responses of the route table
// depends on lpm_pkg
interface lpm_req_if;
  logic              valid;
  logic              ready;
  lpm_pkg::lpm_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpm_rsp_if;
  logic              valid;
  logic              ready;
  lpm_pkg::lpm_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/ipv4_longest_prefix_match.sv -----
// ipv4 longest prefix match: route table memory, scan sequencer and shared compare
// depends on lpm_pkg and the channel interfaces in lpm_if.sv
//
// A write beat loads or clears one slot and gives an all-zero response from
// the response state through the output register. A lookup beat scans the
// table one slot per cycle through the single read port of the route memory,
// with one masked compare and magnitude compare against the best mask so
// far, then goes through the drain and response states to the output register.
// SLOTS is TABLE_DEPTH but at most 16, since the 4-bit slot field reaches no
// further. The block takes one beat at a time; a finished response sits in
// an output register, so the next beat is taken while it waits. Masks compare
// as unsigned numbers, later slots win ties; a zero mask acts as a default route.
module ipv4_longest_prefix_match #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  lpm_req_if.sink  req,
  lpm_rsp_if.source rsp
);
  import lpm_pkg::*;

  localparam int SLOTS = (TABLE_DEPTH < (1 << SLOT_W)) ? TABLE_DEPTH : (1 << SLOT_W);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  lpm_state_t state, state_next;

  route_t             mem [SLOTS];
  logic [SLOTS-1:0]   valid;

  logic [IDX_W-1:0]   rd_idx;
  route_t             rd_data;
  logic               rd_valid;
  logic               cmp_en;
  logic [IDX_W-1:0]   cmp_idx;
  logic [ADDR_W-1:0]  lookup_addr;

  logic               best_hit;
  logic [SLOT_W-1:0]  best_slot;
  logic [ADDR_W-1:0]  best_mask;
  logic [ADDR_W-1:0]  best_gw;
  logic [PORT_W-1:0]  best_port;

  logic               out_valid;
  lpm_rsp_t           out_data;

  logic               accept;
  logic               wr_hit;
  logic [IDX_W-1:0]   wr_idx;
  logic               rd_last;
  logic               match;
  logic               out_load;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign wr_hit    = accept && (req.data.op == OP_WRITE) &&
                     ({1'b0, req.data.slot} < SLOT_LIMIT);
  assign wr_idx    = IDX_W'(req.data.slot);
  assign rd_last   = (rd_idx == LAST_IDX);
  assign out_load  = (state == ST_RESP) && (!out_valid || rsp.ready);

  // shared unit: masked address compare and mask magnitude compare
  assign match = rd_valid &&
                 (((lookup_addr ^ rd_data.prefix) & rd_data.mask) == '0) &&
                 (best_mask <= rd_data.mask);

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.data.op == OP_LOOKUP) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // route memory: one write port from the request, one registered read port
  always_ff @(posedge clk) begin
    if (wr_hit && req.data.entry_enable) begin
      mem[wr_idx] <= '{prefix:  req.data.entry_prefix,
                       mask:    req.data.entry_mask,
                       gateway: req.data.entry_gateway,
                       port:    req.data.entry_port};
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_hit) begin
        valid[wr_idx] <= req.data.entry_enable;
      end
      rd_valid <= valid[rd_idx];
    end
  end

  // scan counter and compare stage, which works on the registered read in the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
      rd_idx <= '0;
    end else begin
      cmp_en <= (state == ST_SCAN);
      if (accept) begin
        rd_idx <= '0;
      end else if (state == ST_SCAN && !rd_last) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx;
    if (accept) begin
      lookup_addr <= req.data.lookup_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_hit <= 1'b0;
    end else if (accept) begin
      best_hit <= 1'b0;
    end else if (cmp_en && match) begin
      best_hit <= 1'b1;
    end
  end

  // best-so-far starts at zero, so a miss or a write reads out as all zero
  always_ff @(posedge clk) begin
    if (accept) begin
      best_slot <= '0;
      best_mask <= '0;
      best_gw   <= '0;
      best_port <= '0;
    end else if (cmp_en && match) begin
      best_slot <= SLOT_W'(cmp_idx);
      best_mask <= rd_data.mask;
      best_gw   <= rd_data.gateway;
      best_port <= rd_data.port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{found:        best_hit,
                    matched_slot: best_slot,
                    next_hop:     best_gw,
                    out_port:     best_port,
                    match_mask:   best_mask};
    end
  end

endmodule
